// File: hdl/velocity_command_packet_encoder_unit_assert.svh
// assertion macros for the velocity command packet encoder
// expects clk and rst_n in the scope where the macros are used
`ifndef VELOCITY_COMMAND_PACKET_ENCODER_UNIT_ASSERT_SVH
`define VELOCITY_COMMAND_PACKET_ENCODER_UNIT_ASSERT_SVH

// condition holds at every clock edge out of reset
`define VCPE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent holds in the clock cycle after the antecedent
`define VCPE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/vcpe_pkg.sv
// types and constants for the velocity command packet encoder
// no dependencies
package vcpe_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [3:0] byte_idx_t;

    localparam int unsigned FrameLen = 14;
    localparam byte_idx_t LastIdx = 4'd13;

    localparam byte_t FrameHeader = 8'h99;
    localparam logic [9:0] LinScale = 10'd487;
    localparam logic [10:0] VelLimit = 11'd2047;

    // ceil(2^24 / 45), exact floor division for dividends up to 2^18
    localparam logic [18:0] AngRecip = 19'd372828;

    localparam logic [3:0] CounterWrap = 4'd8;

endpackage

// File: hdl/velocity_command_packet_encoder_unit.sv
// velocity command packet encoder: command word in, fourteen-byte frame out
// depends on vcpe_pkg and velocity_command_packet_encoder_unit_assert.svh
//
//   channel  signals                                          direction
//   in       in_valid, in_stall, vel_forward, vel_normal,      command word in
//            vel_angular, robot_id
//   out      out_valid, out_stall, frame_byte, frame_last      frame byte out
//
// each frame leaves one byte per cycle while out_stall is low, from a
// 14-byte shift register. a command waits in the input register while the
// previous frame drains, so frames follow each other with no gap.
// scaling and packing are combinational between the input and frame registers.
// reset clears valids, the byte index and the frame counter.
// out_stall holds the current byte; in_stall rises while a command waits.
`include "velocity_command_packet_encoder_unit_assert.svh"

module velocity_command_packet_encoder_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  vel_forward,
    input  logic signed [15:0]  vel_normal,
    input  logic signed [17:0]  vel_angular,
    input  logic [3:0]          robot_id,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          frame_byte,
    output logic                frame_last
);

    function automatic logic [11:0] lin_code(input logic signed [15:0] q);
        logic signed [26:0] prod;
        logic signed [16:0] scaled;
        logic [16:0]        absval;
        logic [10:0]        magn;
        prod   = q * $signed({1'b0, vcpe_pkg::LinScale});
        scaled = prod[24:8];
        absval = scaled[16] ? 17'(-scaled) : 17'(scaled);
        magn   = (absval > {6'd0, vcpe_pkg::VelLimit}) ? vcpe_pkg::VelLimit : absval[10:0];
        return {scaled[16], magn};
    endfunction

    logic                   cmd_valid_reg;
    logic signed [15:0]     fwd_reg;
    logic signed [15:0]     nrm_reg;
    logic signed [17:0]     ang_reg;
    logic [3:0]             id_reg;

    vcpe_pkg::byte_t        frame_reg [vcpe_pkg::FrameLen];
    vcpe_pkg::byte_t        frame_next [vcpe_pkg::FrameLen];
    logic                   frame_valid_reg;
    vcpe_pkg::byte_idx_t    idx_reg;
    logic [3:0]             cnt_reg;
    logic [3:0]             cnt_next;

    logic                   in_accept;
    logic                   out_accept;
    logic                   frame_take;
    logic                   load;

    logic [11:0]            f_code;
    logic [11:0]            n_code;
    logic                   a_sign;
    logic [17:0]            a_abs;
    logic [37:0]            a_prod;
    logic [13:0]            a_quot;
    logic [10:0]            a_mag;
    logic                   a_neg;

    assign out_accept = frame_valid_reg && !out_stall;
    assign frame_take = !frame_valid_reg || (out_accept && frame_last);
    assign load       = cmd_valid_reg && frame_take;
    assign in_stall   = cmd_valid_reg && !frame_take;
    assign in_accept  = in_valid && !in_stall;

    assign out_valid  = frame_valid_reg;
    assign frame_byte = frame_reg[0];
    assign frame_last = (idx_reg == vcpe_pkg::LastIdx);

    always_comb
    begin
        f_code = lin_code(fwd_reg);
        n_code = lin_code(nrm_reg);

        a_sign = ang_reg[17];
        a_abs  = a_sign ? 18'(-ang_reg) : 18'(ang_reg);
        a_prod = 38'({a_abs, 1'b0}) * 38'(vcpe_pkg::AngRecip);
        a_quot = a_prod[37:24];
        a_mag  = (a_quot > {3'd0, vcpe_pkg::VelLimit}) ? vcpe_pkg::VelLimit : a_quot[10:0];
        a_neg  = a_sign && (a_mag != 11'd0);

        for (int k = 0; k < vcpe_pkg::FrameLen; k++)
        begin
            frame_next[k] = 8'h00;
        end
        frame_next[0]  = vcpe_pkg::FrameHeader;
        frame_next[1]  = {4'd0, id_reg};
        frame_next[3]  = {1'b0, a_mag[10:7], 3'd0};
        frame_next[4]  = {1'b0, f_code[6:0]};
        frame_next[5]  = {1'b0, n_code[6:0]};
        frame_next[6]  = {2'd0, n_code[11], f_code[11], f_code[10:7]};
        frame_next[7]  = {1'b0, a_mag[6:0]};
        frame_next[8]  = {1'b0, n_code[10:7], a_neg, 1'b0, 1'b1};
        frame_next[11] = {5'd0, cnt_reg[2:0]};

        cnt_next = (cnt_reg < vcpe_pkg::CounterWrap) ? 4'(cnt_reg + 4'd1) : 4'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg   <= 1'b0;
            frame_valid_reg <= 1'b0;
            idx_reg         <= '0;
            cnt_reg         <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                cmd_valid_reg <= 1'b1;
            end
            else if (load)
            begin
                cmd_valid_reg <= 1'b0;
            end

            if (load)
            begin
                frame_valid_reg <= 1'b1;
                idx_reg         <= '0;
                cnt_reg         <= cnt_next;
            end
            else if (out_accept)
            begin
                if (frame_last)
                begin
                    frame_valid_reg <= 1'b0;
                end
                idx_reg <= vcpe_pkg::byte_idx_t'(idx_reg + 4'd1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            fwd_reg <= vel_forward;
            nrm_reg <= vel_normal;
            ang_reg <= vel_angular;
            id_reg  <= robot_id;
        end

        if (load)
        begin
            frame_reg <= frame_next;
        end
        else if (out_accept)
        begin
            for (int k = 0; k < vcpe_pkg::FrameLen - 1; k++)
            begin
                frame_reg[k] <= frame_reg[k + 1];
            end
        end
    end

    `VCPE_ASSERT_ALWAYS(a_idx_range,
        !frame_valid_reg || (idx_reg <= vcpe_pkg::LastIdx),
        "byte index past end of frame")
    `VCPE_ASSERT_ALWAYS(a_cnt_range, cnt_reg <= vcpe_pkg::CounterWrap,
        "frame counter above wrap value")
    `VCPE_ASSERT_NEXT(a_load_start, load,
        frame_valid_reg && (idx_reg == 4'd0) && (frame_byte == vcpe_pkg::FrameHeader),
        "frame did not start with header")
    `VCPE_ASSERT_NEXT(a_drain_end, out_accept && frame_last && !cmd_valid_reg,
        !frame_valid_reg, "frame still valid after last byte")

endmodule
